/* sv/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while reset is low
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hrfs_pkg.sv */
package hrfs_pkg;

  // default width of the byte offset counters
  localparam int OFFSET_BITS_DEF = 16;

  // reset value of the header limit register
  localparam logic [6:0] HDR_LIMIT_RST = 7'd100;

  // result queue, in word pairs
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // delimiter characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // field kinds
  localparam logic [2:0] KIND_METHOD = 3'd0;
  localparam logic [2:0] KIND_URI    = 3'd1;
  localparam logic [2:0] KIND_PROTO  = 3'd2;
  localparam logic [2:0] KIND_NAME   = 3'd3;
  localparam logic [2:0] KIND_VALUE  = 3'd4;
  localparam logic [2:0] KIND_BODY   = 3'd5;

  // request status and fault codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MALFORMED = 2'd1;
  localparam logic [1:0] STAT_HDRS      = 2'd2;
  localparam logic [1:0] STAT_LONG      = 2'd3;

  // one result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [6:0]  hnum;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // results of one input byte: one or two words
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } pair_t;

endpackage

/* sv/hrfs_result_queue.sv */
module hrfs_result_queue import hrfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  pair_t             push_data,
  output logic [QCNT_W-1:0] count,
  output logic              out_valid,
  input  logic              out_ready,
  output result_t           out_data
);

  pair_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              sub_r, sub_nxt;
  logic              take, pop;
  pair_t             head;

  // head entry and word within it
  assign head      = mem[rd_ptr_r];
  assign out_valid = (count_r != '0);
  assign out_data  = sub_r ? head.r1 : head.r0;
  assign count     = count_r;

  assign take = out_valid && out_ready;
  assign pop  = take && (sub_r || !head.two);

  // entry storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // occupancy and word select
  always_comb begin
    count_nxt = count_r;
    if (push_valid && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push_valid && pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
    sub_nxt = sub_r;
    if (pop) begin
      sub_nxt = 1'b0;
    end else if (take) begin
      sub_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

/* sv/http_request_field_splitter_unit.sv */
// path: a taken byte waits in the input stage; its result words go to the queue
// throughput: one byte per cycle while the queue holds at most two word pairs; a
//   byte that ends a field on the last byte of a request gives two words, and a
//   queue of four word pairs absorbs such bursts
// reset: synchronous, active low; clears the parse state and queue, and sets the
//   header limit back to 100
module http_request_field_splitter_unit import hrfs_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // final_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // field_start, field_length, header_number, status
  output logic [2:0]  out_tuser,  // field_kind
  output logic        out_tlast,  // run_last
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data // header_limit
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic [8:0] {
    PH_METHOD = 9'b000000001,
    PH_URI    = 9'b000000010,
    PH_PROTO  = 9'b000000100,
    PH_LINE   = 9'b000001000,
    PH_NAME   = 9'b000010000,
    PH_SKIP   = 9'b000100000,
    PH_VALUE  = 9'b001000000,
    PH_BODY   = 9'b010000000,
    PH_FAILED = 9'b100000000
  } phase_t;

  // input stage
  logic                   stg_valid_r;
  logic [7:0]             stg_byte_r;
  logic                   stg_fin_r;

  // parse state
  phase_t                 phase_r, phase_nxt;
  logic                   pend_cr_r, pend_cr_nxt;
  logic [OFFSET_BITS-1:0] origin_r, origin_nxt;
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic [6:0]             hdr_seen_r, hdr_seen_nxt;
  logic [1:0]             fault_r, fault_nxt;
  logic [6:0]             hdr_limit_r;

  // step working values
  logic [OFFSET_BITS-1:0] off_p1, off_m1, len_cur, len_crlf, len_body;
  logic                   do_hdr, is_ws;
  logic                   emit_a;
  result_t                res_a, res_b;
  pair_t                  pair;
  logic                   push;
  logic [QCNT_W-1:0]      q_count;
  result_t                q_word;

  // accept while the queue can take this byte and the one in the stage
  assign in_tready = (q_count <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_byte_r <= in_tdata;
      stg_fin_r  <= in_tlast;
    end
  end

  // header limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_limit_r <= HDR_LIMIT_RST;
    end else if (cfg_wr_en) begin
      hdr_limit_r <= cfg_wr_data;
    end
  end

  assign off_p1 = offset_r + OFFSET_BITS'(1);
  assign off_m1 = offset_r - OFFSET_BITS'(1);
  assign is_ws  = (stg_byte_r == CH_SPACE) ||
                  ((stg_byte_r >= CH_TAB) && (stg_byte_r <= CH_CR));

  // byte step: phase update and field emission
  always_comb begin
    phase_nxt    = phase_r;
    pend_cr_nxt  = pend_cr_r;
    origin_nxt   = origin_r;
    hdr_seen_nxt = hdr_seen_r;
    fault_nxt    = fault_r;
    do_hdr       = 1'b0;
    emit_a       = 1'b0;
    res_a        = '0;
    len_cur      = '0;
    len_crlf     = '0;

    // offset counter at its top: request too long
    if (phase_r != PH_FAILED && offset_r == OFF_MAX) begin
      fault_nxt   = STAT_LONG;
      phase_nxt   = PH_FAILED;
      pend_cr_nxt = 1'b0;
    end

    unique case (phase_nxt)
      PH_METHOD, PH_URI: begin
        if (stg_byte_r == CH_SPACE) begin
          len_cur      = offset_r - origin_r;
          emit_a       = 1'b1;
          res_a.kind   = (phase_nxt == PH_METHOD) ? KIND_METHOD : KIND_URI;
          res_a.start  = 16'(origin_r);
          res_a.length = 16'(len_cur);
          phase_nxt    = (phase_nxt == PH_METHOD) ? PH_URI : PH_PROTO;
          origin_nxt   = off_p1;
        end
      end
      PH_PROTO: begin
        if (pend_cr_r && stg_byte_r == CH_LF) begin
          len_crlf     = off_m1 - origin_r;
          emit_a       = 1'b1;
          res_a.kind   = KIND_PROTO;
          res_a.start  = 16'(origin_r);
          res_a.length = 16'(len_crlf);
          pend_cr_nxt  = 1'b0;
          phase_nxt    = PH_LINE;
          origin_nxt   = off_p1;
        end else begin
          pend_cr_nxt = (stg_byte_r == CH_CR);
        end
      end
      PH_LINE: begin
        if (pend_cr_r) begin
          pend_cr_nxt = 1'b0;
          if (stg_byte_r == CH_LF) begin
            phase_nxt  = PH_BODY;
            origin_nxt = off_p1;
          end else begin
            do_hdr = 1'b1;
          end
        end else if (stg_byte_r == CH_CR) begin
          pend_cr_nxt = 1'b1;
        end else begin
          origin_nxt = offset_r;
          do_hdr     = 1'b1;
        end
        // a header line begins here
        if (do_hdr) begin
          if (hdr_seen_r >= hdr_limit_r) begin
            fault_nxt   = STAT_HDRS;
            phase_nxt   = PH_FAILED;
            pend_cr_nxt = 1'b0;
          end else if (stg_byte_r == CH_COLON) begin
            len_cur      = offset_r - origin_nxt;
            emit_a       = 1'b1;
            res_a.kind   = KIND_NAME;
            res_a.start  = 16'(origin_nxt);
            res_a.length = 16'(len_cur);
            res_a.hnum   = hdr_seen_r;
            phase_nxt    = PH_SKIP;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (stg_byte_r == CH_COLON) begin
          len_cur      = offset_r - origin_r;
          emit_a       = 1'b1;
          res_a.kind   = KIND_NAME;
          res_a.start  = 16'(origin_r);
          res_a.length = 16'(len_cur);
          res_a.hnum   = hdr_seen_r;
          phase_nxt    = PH_SKIP;
        end
      end
      PH_SKIP: begin
        // first non-blank byte opens the value
        if (!is_ws) begin
          phase_nxt   = PH_VALUE;
          origin_nxt  = offset_r;
          pend_cr_nxt = (stg_byte_r == CH_CR);
        end
      end
      PH_VALUE: begin
        if (pend_cr_r && stg_byte_r == CH_LF) begin
          len_crlf     = off_m1 - origin_r;
          emit_a       = 1'b1;
          res_a.kind   = KIND_VALUE;
          res_a.start  = 16'(origin_r);
          res_a.length = 16'(len_crlf);
          res_a.hnum   = hdr_seen_r;
          pend_cr_nxt  = 1'b0;
          hdr_seen_nxt = hdr_seen_r + 7'd1;
          phase_nxt    = PH_LINE;
          origin_nxt   = off_p1;
        end else begin
          pend_cr_nxt = (stg_byte_r == CH_CR);
        end
      end
      default: begin
      end
    endcase

    // saturating byte offset
    offset_nxt = (offset_r != OFF_MAX) ? off_p1 : offset_r;

    // end of request word
    len_body = offset_nxt - origin_nxt;
    res_b    = '0;
    res_b.kind = KIND_BODY;
    res_b.last = 1'b1;
    if (phase_nxt == PH_BODY && fault_nxt == STAT_OK) begin
      res_b.start  = 16'(origin_nxt);
      res_b.length = 16'(len_body);
    end else begin
      res_b.status = (fault_nxt != STAT_OK) ? fault_nxt : STAT_MALFORMED;
    end
  end

  // pack the words of this byte
  always_comb begin
    pair.two     = emit_a && stg_fin_r;
    pair.r0      = emit_a ? res_a : res_b;
    pair.r0.last = !(emit_a && stg_fin_r);
    pair.r1      = res_b;
  end

  assign push = stg_valid_r && (emit_a || stg_fin_r);

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_METHOD;
      pend_cr_r  <= 1'b0;
      origin_r   <= '0;
      offset_r   <= '0;
      hdr_seen_r <= '0;
      fault_r    <= STAT_OK;
    end else if (stg_valid_r) begin
      if (stg_fin_r) begin
        phase_r    <= PH_METHOD;
        pend_cr_r  <= 1'b0;
        origin_r   <= '0;
        offset_r   <= '0;
        hdr_seen_r <= '0;
        fault_r    <= STAT_OK;
      end else begin
        phase_r    <= phase_nxt;
        pend_cr_r  <= pend_cr_nxt;
        origin_r   <= origin_nxt;
        offset_r   <= offset_nxt;
        hdr_seen_r <= hdr_seen_nxt;
        fault_r    <= fault_nxt;
      end
    end
  end

  // result queue
  hrfs_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push),
    .push_data  (pair),
    .count      (q_count),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (q_word)
  );

  assign out_tdata = {7'd0, q_word.status, q_word.hnum, q_word.length, q_word.start};
  assign out_tuser = q_word.kind;
  assign out_tlast = q_word.last;

endmodule

/* sv/hrfs_checker.sv */
`include "assert_macros.svh"

module hrfs_checker import hrfs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // fields of the result word
  logic        stall;
  logic [51:0] held_word;
  logic [6:0]  hnum;
  logic [1:0]  stat;
  logic [31:0] span;
  logic        hdr_word;
  logic        body_word;

  assign stall     = out_tvalid && !out_tready;
  assign held_word = {out_tlast, out_tuser, out_tdata};
  assign hnum      = out_tdata[38:32];
  assign stat      = out_tdata[40:39];
  assign span      = out_tdata[31:0];
  assign hdr_word  = (out_tuser == KIND_NAME) || (out_tuser == KIND_VALUE);
  assign body_word = (out_tuser == KIND_BODY);

  // a stalled word holds
  `CHK_NEXT(a_out_hold, stall, out_tvalid && $stable(held_word), "stalled result word changed")

  // only defined kinds leave the block
  `CHK_IMPLY(a_kind_range, out_tvalid, out_tuser <= KIND_BODY, "field kind out of range")

  // header index only on header name and value words
  `CHK_IMPLY(a_hnum_kind, out_tvalid && !hdr_word, hnum == 7'd0, "header index on a non-header word")

  // end of request closes the run of a byte
  `CHK_IMPLY(a_body_last, out_tvalid && body_word, out_tlast, "end of request word not last")

  // a failed request reports no body span
  `CHK_IMPLY(a_fail_zero, out_tvalid && stat != STAT_OK, body_word && span == '0, "bad status word")

endmodule

bind http_request_field_splitter_unit hrfs_checker u_hrfs_checker (.*);
